// ===== hdl/jsu_pkg.sv =====
// Package for the JSON string unescaper: word types, status codes and
// UTF-8 constants. No dependencies.
`timescale 1ns / 1ps

package jsu_pkg;

  typedef enum logic [2:0] {
    StRun       = 3'd0,
    StClosed    = 3'd1,
    StNoOpen    = 3'd2,
    StUnterm    = 3'd3,
    StUntermEsc = 3'd4,
    StBadEsc    = 3'd5,
    StBadUni    = 3'd6
  } status_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    status_e    status;
    logic       last;
  } out_word_t;

  // All results caused by one input word: up to three bytes, a count of
  // zero meaning a single result that carries no byte.
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      count;
    status_e         status;
  } group_t;

  localparam int unsigned GroupFifoDepth = 4;

  localparam logic [7:0]  Utf8Lead2 = 8'hC0;
  localparam logic [7:0]  Utf8Lead3 = 8'hE0;
  localparam logic [7:0]  Utf8Cont  = 8'h80;
  localparam logic [5:0]  Utf8Mask  = 6'h3F;
  localparam logic [15:0] Utf8OneLimit = 16'h0080;
  localparam logic [15:0] Utf8TwoLimit = 16'h0800;

endpackage

// ===== hdl/jsu_decoder.sv =====
// Parser state and combinational decode of one input word to a result group.
// Depends on jsu_pkg.
`timescale 1ns / 1ps

module jsu_decoder (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  jsu_pkg::in_word_t word_i,
  output jsu_pkg::group_t   group_o
);
  import jsu_pkg::*;

  typedef enum logic [1:0] {
    ModeWait = 2'd0,
    ModeBody = 2'd1,
    ModeEsc  = 2'd2,
    ModeHex  = 2'd3
  } mode_e;

  mode_e       mode_q, mode_d;
  logic [1:0]  digits_q, digits_d;
  logic [15:0] cp_q, cp_d;
  logic [15:0] cp_new;
  logic [4:0]  hex;
  logic [7:0]  b;
  logic        eoi;
  group_t      grp;

  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  assign b      = word_i.in_byte;
  assign eoi    = word_i.end_of_input;
  assign hex    = hex_value(b);
  assign cp_new = {cp_q[11:0], hex[3:0]};

  always_comb begin
    mode_d     = mode_q;
    digits_d   = digits_q;
    cp_d       = cp_q;
    grp.bytes  = '0;
    grp.count  = 2'd0;
    grp.status = StRun;
    unique case (mode_q)
      ModeWait: begin
        if (b == 8'h22) begin
          if (eoi) begin
            grp.status = StUnterm;
          end else begin
            mode_d = ModeBody;
          end
        end else begin
          grp.status = StNoOpen;
        end
      end
      ModeBody: begin
        if (b == 8'h22) begin
          grp.status = StClosed;
          mode_d     = ModeWait;
        end else if (b == 8'h5C) begin
          if (eoi) begin
            grp.status = StUntermEsc;
            mode_d     = ModeWait;
          end else begin
            mode_d = ModeEsc;
          end
        end else begin
          grp.bytes[0] = b;
          grp.count    = 2'd1;
          if (eoi) begin
            grp.status = StUnterm;
            mode_d     = ModeWait;
          end
        end
      end
      ModeEsc: begin
        if (b == 8'h75) begin
          digits_d = 2'd0;
          cp_d     = '0;
          if (eoi) begin
            grp.status = StBadUni;
            mode_d     = ModeWait;
          end else begin
            mode_d = ModeHex;
          end
        end else begin
          grp.count = 2'd1;
          case (b)
            8'h22:   grp.bytes[0] = 8'h22;
            8'h5C:   grp.bytes[0] = 8'h5C;
            8'h2F:   grp.bytes[0] = 8'h2F;
            8'h6E:   grp.bytes[0] = 8'h0A;
            8'h74:   grp.bytes[0] = 8'h09;
            8'h72:   grp.bytes[0] = 8'h0D;
            8'h62:   grp.bytes[0] = 8'h08;
            8'h66:   grp.bytes[0] = 8'h0C;
            default: grp.count    = 2'd0;
          endcase
          if (grp.count == 2'd0) begin
            grp.status = StBadEsc;
            mode_d     = ModeWait;
          end else if (eoi) begin
            grp.status = StUnterm;
            mode_d     = ModeWait;
          end else begin
            mode_d = ModeBody;
          end
        end
      end
      ModeHex: begin
        if (!hex[4]) begin
          grp.status = StBadUni;
          mode_d     = ModeWait;
        end else begin
          cp_d = cp_new;
          if (digits_q == 2'd3) begin
            if (cp_new < Utf8OneLimit) begin
              grp.bytes[0] = cp_new[7:0];
              grp.count    = 2'd1;
            end else if (cp_new < Utf8TwoLimit) begin
              grp.bytes[0] = Utf8Lead2 | {3'b000, cp_new[10:6]};
              grp.bytes[1] = Utf8Cont | {2'b00, cp_new[5:0] & Utf8Mask};
              grp.count    = 2'd2;
            end else begin
              grp.bytes[0] = Utf8Lead3 | {4'b0000, cp_new[15:12]};
              grp.bytes[1] = Utf8Cont | {2'b00, cp_new[11:6] & Utf8Mask};
              grp.bytes[2] = Utf8Cont | {2'b00, cp_new[5:0] & Utf8Mask};
              grp.count    = 2'd3;
            end
            digits_d = 2'd0;
            if (eoi) begin
              grp.status = StUnterm;
              mode_d     = ModeWait;
            end else begin
              mode_d = ModeBody;
            end
          end else begin
            digits_d = digits_q + 2'd1;
            if (eoi) begin
              grp.status = StBadUni;
              mode_d     = ModeWait;
            end
          end
        end
      end
      default: mode_d = ModeWait;
    endcase
  end

  assign group_o = grp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= ModeWait;
      digits_q <= 2'd0;
      cp_q     <= '0;
    end else if (accept_i) begin
      mode_q   <= mode_d;
      digits_q <= digits_d;
      cp_q     <= cp_d;
    end
  end

endmodule

// ===== hdl/jsu_out_queue.sv =====
// Queue of decoded result groups, unpacked into one output word per cycle
// while stall_i is low. Depends on jsu_pkg.
`timescale 1ns / 1ps

module jsu_out_queue #(
  parameter int unsigned Depth = jsu_pkg::GroupFifoDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  jsu_pkg::group_t    group_i,
  output logic               full_o,
  output logic               valid_o,
  input  logic               stall_i,
  output jsu_pkg::out_word_t word_o
);
  import jsu_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  group_t            entries_q [Depth];
  logic [PtrW-1:0]   wr_q, rd_q;
  logic [CntW-1:0]   cnt_q;
  logic [1:0]        pos_q;
  group_t            head;
  logic              head_last;
  logic              pop;

  assign head      = entries_q[rd_q];
  assign head_last = (head.count == 2'd0) || (pos_q == head.count - 2'd1);
  assign valid_o   = (cnt_q != '0);
  assign full_o    = (cnt_q == CntW'(Depth));
  assign pop       = valid_o && !stall_i && head_last;

  always_comb begin
    word_o.out_byte   = (head.count == 2'd0) ? 8'h00 : head.bytes[pos_q];
    word_o.byte_valid = (head.count != 2'd0);
    word_o.status     = head.status;
    word_o.last       = head_last;
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_q] <= group_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
      pos_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (valid_o && !stall_i) begin
        if (head_last) begin
          pos_q <= 2'd0;
          rd_q  <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
        end else begin
          pos_q <= pos_q + 2'd1;
        end
      end
      if (push_i && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/json_string_unescaper.sv =====
// Top level of the JSON string unescaper: decoder followed by the result queue.
// Depends on jsu_pkg, jsu_decoder and jsu_out_queue.
`timescale 1ns / 1ps

// Takes one input word per cycle and decodes it combinationally into one to
// three output words, queued as one group and delivered one per cycle when not
// stalled. Input is stalled only while the group queue (Depth groups) is full,
// so the sustained input rate is one word per cycle except after a \u escape
// of two or three UTF-8 bytes, where the single output port sets the pace.
module json_string_unescaper #(
  parameter int unsigned Depth = jsu_pkg::GroupFifoDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  jsu_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output jsu_pkg::out_word_t out_word_o
);
  import jsu_pkg::*;

  logic   accept;
  logic   full;
  group_t grp;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  jsu_decoder u_decoder (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .word_i   (in_word_i),
    .group_o  (grp)
  );

  jsu_out_queue #(
    .Depth (Depth)
  ) u_out_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .group_i (grp),
    .full_o  (full),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .word_o  (out_word_o)
  );

endmodule
